/* rtl/core/sip_pkg.sv */
package sip_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned BASE_W  = 6;
  localparam int unsigned OFFS_W  = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CHAR_W-1:0] CH_TAB    = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_X   = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_X   = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7a;
  localparam logic [CHAR_W-1:0] UPPER_OFS = CH_UP_A - 8'd10;
  localparam logic [CHAR_W-1:0] LOWER_OFS = CH_LO_A - 8'd10;

  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

  localparam logic [BASE_W-1:0] RST_NUMBER_BASE = BASE_DEC;
  localparam logic              RST_SIGNED_MODE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMBER_BASE = 1'b0,
    CFG_SIGNED_MODE = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    DS_NONE   = 2'd0,
    DS_DIGITS = 2'd1,
    DS_OVF    = 2'd2
  } dstat_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              first_char;
    logic              last_char;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               range_error;
    logic [OFFS_W-1:0]  end_offset;
    logic               digits_found;
  } result_t;

endpackage

/* rtl/core/string_to_integer_parser_unit.sv */
// Timing: the character that ends the number is held in the input register, and the
//   result beat is loaded into the output register when that character is consumed.
// Throughput: 1 character per cycle when the output is free, set by the combinational
//   multiply-add-compare on the accumulator; at most one result beat per string.
// Reset (rst, synchronous): clears both valid flags and the parse state and loads
//   number_base = 10, signed_mode = 1.
module string_to_integer_parser_unit #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned MAX_CHARS = 255
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [sip_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sip_pkg::BASE_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sip_pkg::CHAR_W-1:0]          char_code,
  input  logic                                first_char,
  input  logic                                last_char,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sip_pkg::VALUE_W-1:0]         value,
  output logic                                range_error,
  output logic [sip_pkg::OFFS_W-1:0]          end_offset,
  output logic                                digits_found
);

  logic [sip_pkg::BASE_W-1:0] number_base;
  logic                       signed_mode;
  sip_pkg::item_t             item_in, item;
  sip_pkg::result_t           res_core, res;
  logic                       item_valid, consume, emit, out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= sip_pkg::RST_NUMBER_BASE;
      signed_mode <= sip_pkg::RST_SIGNED_MODE;
    end else if (cfg_write) begin
      unique case (sip_pkg::cfg_idx_t'(cfg_index))
        sip_pkg::CFG_NUMBER_BASE: number_base <= cfg_data;
        sip_pkg::CFG_SIGNED_MODE: signed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign item_in.char_code  = char_code;
  assign item_in.first_char = first_char;
  assign item_in.last_char  = last_char;
  assign consume = item_valid && out_free;

  sip_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item_in    (item_in),
    .consume    (consume),
    .item_valid (item_valid),
    .item       (item)
  );

  sip_parse_core #(
    .WORD_BITS (WORD_BITS),
    .MAX_CHARS (MAX_CHARS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (consume),
    .item        (item),
    .number_base (number_base),
    .signed_mode (signed_mode),
    .emit        (emit),
    .result      (res_core)
  );

  sip_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (consume && emit),
    .res_in    (res_core),
    .out_ready (out_ready),
    .out_free  (out_free),
    .out_valid (out_valid),
    .res       (res)
  );

  assign value        = res.value;
  assign range_error  = res.range_error;
  assign end_offset   = res.end_offset;
  assign digits_found = res.digits_found;

endmodule

/* rtl/core/sip_in_stage.sv */
module sip_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sip_pkg::item_t item_in,
  input  logic           consume,
  output logic           item_valid,
  output sip_pkg::item_t item
);

  assign in_ready = !item_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_in;
    end
  end

endmodule

/* rtl/core/sip_parse_core.sv */
module sip_parse_core #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned MAX_CHARS = 255
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  sip_pkg::item_t                  item,
  input  logic [sip_pkg::BASE_W-1:0]      number_base,
  input  logic                            signed_mode,
  output logic                            emit,
  output sip_pkg::result_t                result
);

  localparam int unsigned POS_W  = $clog2(MAX_CHARS + 1);
  localparam int unsigned EXT_W  = (POS_W > sip_pkg::OFFS_W) ? POS_W : sip_pkg::OFFS_W;
  localparam int unsigned PROD_W = WORD_BITS + sip_pkg::BASE_W + 1;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CHARS);

  sip_pkg::phase_t       phase, ph0, phase_next;
  sip_pkg::dstat_t       dstat, ds0, dstat_next, dig_ds, dig_ds_nx;
  logic                  neg, neg0, neg_next;
  logic [WORD_BITS-1:0]  acc, acc0, acc_next, dig_acc, dig_acc_nx;
  logic [sip_pkg::BASE_W-1:0] abase, ab0, abase_next, body_base, dig_base;
  logic [POS_W-1:0]      cpos, pos0, cpos_next, end_pos;
  logic [EXT_W-1:0]      end_ext;
  logic [sip_pkg::CHAR_W-1:0] c;
  logic                  is_space, dv_ok, body_zero, dig_ends, dig_ovf;
  logic                  run_body, run_digit, ends, live;
  logic [sip_pkg::BASE_W-1:0] dval;
  logic [PROD_W-1:0]     prod, lim_ext;
  logic [WORD_BITS-1:0]  sign_bit, lim, word_val;

  assign c = item.char_code;
  assign sign_bit = {1'b1, {(WORD_BITS-1){1'b0}}};

  always_comb begin
    dv_ok = 1'b1;
    dval  = '0;
    if (c >= sip_pkg::CH_ZERO && c <= sip_pkg::CH_NINE) begin
      dval = sip_pkg::BASE_W'(c - sip_pkg::CH_ZERO);
    end else if (c >= sip_pkg::CH_UP_A && c <= sip_pkg::CH_UP_Z) begin
      dval = sip_pkg::BASE_W'(c - sip_pkg::UPPER_OFS);
    end else if (c >= sip_pkg::CH_LO_A && c <= sip_pkg::CH_LO_Z) begin
      dval = sip_pkg::BASE_W'(c - sip_pkg::LOWER_OFS);
    end else begin
      dv_ok = 1'b0;
    end
  end

  always_comb begin
    ph0  = item.first_char ? sip_pkg::PH_SKIP : phase;
    neg0 = item.first_char ? 1'b0 : neg;
    acc0 = item.first_char ? '0 : acc;
    ds0  = item.first_char ? sip_pkg::DS_NONE : dstat;
    ab0  = item.first_char ? '0 : abase;
    pos0 = item.first_char ? '0 : cpos;
    cpos_next = (pos0 >= POS_MAX) ? POS_MAX : pos0 + 1'b1;

    is_space = (c == sip_pkg::CH_SPACE) || (c >= sip_pkg::CH_TAB && c <= sip_pkg::CH_CR);
    body_zero = ((number_base == sip_pkg::BASE_AUTO) || (number_base == sip_pkg::BASE_HEX))
                && (c == sip_pkg::CH_ZERO);
    body_base = (number_base == sip_pkg::BASE_AUTO) ? sip_pkg::BASE_DEC : number_base;

    // one shared multiply-add unit, overflow is acc*b+d above the limit
    dig_base = ((ph0 == sip_pkg::PH_ZERO) || (ph0 == sip_pkg::PH_DIGITS)) ? ab0 : body_base;
    dig_acc  = (ph0 == sip_pkg::PH_ZERO) ? '0 : acc0;
    dig_ds   = (ph0 == sip_pkg::PH_ZERO) ? sip_pkg::DS_DIGITS : ds0;
    dig_ends = !dv_ok || (dval >= dig_base);
    lim = !signed_mode ? {WORD_BITS{1'b1}} : (neg0 ? sign_bit : sign_bit - 1'b1);
    lim_ext = PROD_W'(lim);
    prod = PROD_W'(dig_acc) * PROD_W'(dig_base) + PROD_W'(dval);
    dig_ovf = (dig_ds == sip_pkg::DS_OVF) || (prod > lim_ext);
    dig_acc_nx = dig_ovf ? dig_acc : prod[WORD_BITS-1:0];
    dig_ds_nx  = dig_ovf ? sip_pkg::DS_OVF : sip_pkg::DS_DIGITS;

    phase_next = ph0;
    neg_next   = neg0;
    acc_next   = acc0;
    dstat_next = ds0;
    abase_next = ab0;
    run_body   = 1'b0;
    run_digit  = 1'b0;
    ends       = 1'b0;
    live       = 1'b1;

    unique case (ph0)
      sip_pkg::PH_SKIP: begin
        if (is_space) begin
          phase_next = sip_pkg::PH_SKIP;
        end else if (c == sip_pkg::CH_MINUS) begin
          neg_next   = 1'b1;
          phase_next = sip_pkg::PH_SIGN;
        end else if (c == sip_pkg::CH_PLUS) begin
          phase_next = sip_pkg::PH_SIGN;
        end else begin
          run_body = 1'b1;
        end
      end
      sip_pkg::PH_SIGN: begin
        run_body = 1'b1;
      end
      sip_pkg::PH_ZERO: begin
        if (c == sip_pkg::CH_LO_X || c == sip_pkg::CH_UP_X) begin
          abase_next = sip_pkg::BASE_HEX;
          phase_next = sip_pkg::PH_DIGITS;
        end else begin
          run_digit = 1'b1;
        end
      end
      sip_pkg::PH_DIGITS: begin
        run_digit = 1'b1;
      end
      default: begin
        live = 1'b0;
      end
    endcase

    if (run_body) begin
      if (body_zero) begin
        abase_next = (number_base == sip_pkg::BASE_AUTO) ? sip_pkg::BASE_OCT
                                                         : sip_pkg::BASE_HEX;
        phase_next = sip_pkg::PH_ZERO;
      end else begin
        abase_next = body_base;
        run_digit  = 1'b1;
      end
    end

    if (run_digit) begin
      phase_next = sip_pkg::PH_DIGITS;
      if (dig_ends) begin
        acc_next   = dig_acc;
        dstat_next = dig_ds;
        ends       = 1'b1;
      end else begin
        acc_next   = dig_acc_nx;
        dstat_next = dig_ds_nx;
      end
    end

    // a lone zero that closes the string counts as a digit
    if (!ends && item.last_char && phase_next == sip_pkg::PH_ZERO) begin
      acc_next   = '0;
      dstat_next = sip_pkg::DS_DIGITS;
    end

    emit    = live && (ends || item.last_char);
    end_pos = ends ? pos0 : cpos_next;
    if (emit) begin
      phase_next = sip_pkg::PH_DONE;
    end

    if (dstat_next == sip_pkg::DS_OVF) begin
      word_val = !signed_mode ? {WORD_BITS{1'b1}} : (neg_next ? sign_bit : sign_bit - 1'b1);
    end else if (neg_next) begin
      word_val = '0 - acc_next;
    end else begin
      word_val = acc_next;
    end

    end_ext = (dstat_next == sip_pkg::DS_NONE) ? '0 : EXT_W'(end_pos);
    result.value        = sip_pkg::VALUE_W'(word_val);
    result.range_error  = (dstat_next == sip_pkg::DS_OVF);
    result.end_offset   = end_ext[sip_pkg::OFFS_W-1:0];
    result.digits_found = (dstat_next != sip_pkg::DS_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sip_pkg::PH_SKIP;
      neg   <= 1'b0;
      acc   <= '0;
      dstat <= sip_pkg::DS_NONE;
      abase <= '0;
      cpos  <= '0;
    end else if (step) begin
      phase <= phase_next;
      neg   <= neg_next;
      acc   <= acc_next;
      dstat <= dstat_next;
      abase <= abase_next;
      cpos  <= cpos_next;
    end
  end

endmodule

/* rtl/core/sip_out_stage.sv */
module sip_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  sip_pkg::result_t res_in,
  input  logic             out_ready,
  output logic             out_free,
  output logic             out_valid,
  output sip_pkg::result_t res
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      res <= res_in;
    end
  end

endmodule

/* rtl/core/sip_checker.sv */
module sip_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] value,
  input logic        range_error,
  input logic [7:0]  end_offset,
  input logic        digits_found
);

  a_rst_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_no_digits_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !digits_found |-> value == 64'd0 && !range_error && end_offset == 8'd0)
    else $error("empty parse beat carries nonzero fields");

  a_range_needs_digits: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> digits_found)
    else $error("range error without digits");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(end_offset))
    else $error("stalled result beat changed");

endmodule

bind string_to_integer_parser_unit sip_checker u_sip_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .value        (value),
  .range_error  (range_error),
  .end_offset   (end_offset),
  .digits_found (digits_found)
);
